FILE: rtl/clcd_pkg.sv
package clcd_pkg;

  localparam int unsigned PHASE_W = 4;

  localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
  localparam logic [PHASE_W-1:0] PH_POWER     = 4'd1;
  localparam logic [PHASE_W-1:0] PH_EH_INIT   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_REC_INIT  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_INIT_WAIT = 4'd4;
  localparam logic [PHASE_W-1:0] PH_EH_HI     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_REC_HI    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_EH_LO     = 4'd7;
  localparam logic [PHASE_W-1:0] PH_REC_LO    = 4'd8;
  localparam logic [PHASE_W-1:0] PH_SETTLE    = 4'd9;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_INIT = 2'd3;

  localparam logic [2:0] REG_ENABLE_HIGH    = 3'd0;
  localparam logic [2:0] REG_PULSE_RECOVERY = 3'd1;
  localparam logic [2:0] REG_SHORT_SETTLE   = 3'd2;
  localparam logic [2:0] REG_LONG_SETTLE    = 3'd3;
  localparam logic [2:0] REG_POWER_ON       = 3'd4;
  localparam logic [2:0] REG_INIT_LONG      = 3'd5;
  localparam logic [2:0] REG_INIT_SHORT     = 3'd6;

  localparam logic [3:0] IDX_CMD_FIRST = 4'd4;
  localparam logic [3:0] IDX_CMD_LAST  = 4'd7;
  localparam logic [3:0] IDX_SINGLE    = 4'd8;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;

  typedef struct packed {
    logic [7:0]  enable_high;
    logic [15:0] pulse_recovery;
    logic [15:0] short_settle;
    logic [15:0] long_settle;
    logic [15:0] power_on;
    logic [15:0] init_long;
    logic [15:0] init_short;
  } timing_cfg_t;

  function automatic logic [3:0] init_nibble(input logic [1:0] idx);
    logic [3:0] nib;
    case (idx)
      2'd3:    nib = 4'h2;
      default: nib = 4'h3;
    endcase
    return nib;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] cmd;
    case (idx)
      2'd0:    cmd = 8'h28;
      2'd1:    cmd = 8'h0C;
      2'd2:    cmd = 8'h06;
      default: cmd = 8'h01;
    endcase
    return cmd;
  endfunction

endpackage

FILE: rtl/char_lcd_nibble_write_sequencer_unit.sv
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// input    | in_valid, in_stall, in_kind, in_byte_value | in
// result   | out_valid, out_stall, out_enable_line ... out_finished | out
// config   | cfg_we, cfg_index, cfg_data             | in
//
// Every input beat produces one result beat, registered in the cycle after it is accepted.
// One beat is taken per cycle while input is not stalled; the only loop is the phase and wait counter
// update, which finishes within the accepting cycle.
// A result register sits on the output; input is stalled only while that
// register holds a beat that the output side is stalling.
// Reset is synchronous and active low; it restores the default timings.
module char_lcd_nibble_write_sequencer_unit #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_enable_line,
  output logic        out_select_line,
  output logic [3:0]  out_bus_nibble,
  output logic        out_busy_res,
  output logic        out_rejected,
  output logic        out_finished,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  clcd_pkg::timing_cfg_t cfg_r;

  logic [clcd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]       count_r, count_nxt, count_inc, limit;
  logic [7:0]                   pend_r, pend_nxt;
  logic                         sel_r, sel_nxt;
  logic [3:0]                   idx_r, idx_nxt, idx_inc;
  logic [3:0]                   nib_r, nib_nxt;
  logic                         rej, fin, accept;

  logic       out_valid_r;
  logic       en_r, busy_r, rej_r, fin_r;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  clcd_limit #(.COUNT_WIDTH(COUNT_WIDTH)) u_limit (
    .cfg          (cfg_r),
    .phase        (phase_r),
    .init_index   (idx_r),
    .select_level (sel_r),
    .pending_byte (pend_r),
    .limit        (limit)
  );

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    pend_nxt  = pend_r;
    sel_nxt   = sel_r;
    idx_nxt   = idx_r;
    nib_nxt   = nib_r;
    rej       = 1'b0;
    fin       = 1'b0;
    idx_inc   = idx_r + 4'd1;
    count_inc = (count_r < limit) ? count_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : count_r;
    if (in_kind == clcd_pkg::KIND_TICK) begin
      if (phase_r != clcd_pkg::PH_IDLE) begin
        count_nxt = count_inc;
        if (count_inc >= limit) begin
          count_nxt = '0;
          case (phase_r)
            clcd_pkg::PH_POWER: begin
              nib_nxt   = clcd_pkg::init_nibble(idx_r[1:0]);
              phase_nxt = clcd_pkg::PH_EH_INIT;
            end
            clcd_pkg::PH_EH_INIT:  phase_nxt = clcd_pkg::PH_REC_INIT;
            clcd_pkg::PH_REC_INIT: phase_nxt = clcd_pkg::PH_INIT_WAIT;
            clcd_pkg::PH_INIT_WAIT: begin
              if (idx_inc < clcd_pkg::IDX_CMD_FIRST) begin
                idx_nxt   = idx_inc;
                nib_nxt   = clcd_pkg::init_nibble(idx_inc[1:0]);
                phase_nxt = clcd_pkg::PH_EH_INIT;
              end else begin
                idx_nxt   = clcd_pkg::IDX_CMD_FIRST;
                pend_nxt  = clcd_pkg::init_cmd(2'd0);
                nib_nxt   = pend_nxt[7:4];
                phase_nxt = clcd_pkg::PH_EH_HI;
              end
            end
            clcd_pkg::PH_EH_HI: phase_nxt = clcd_pkg::PH_REC_HI;
            clcd_pkg::PH_REC_HI: begin
              nib_nxt   = pend_r[3:0];
              phase_nxt = clcd_pkg::PH_EH_LO;
            end
            clcd_pkg::PH_EH_LO:  phase_nxt = clcd_pkg::PH_REC_LO;
            clcd_pkg::PH_REC_LO: phase_nxt = clcd_pkg::PH_SETTLE;
            default: begin
              if (idx_r >= clcd_pkg::IDX_CMD_FIRST && idx_r < clcd_pkg::IDX_CMD_LAST) begin
                idx_nxt   = idx_inc;
                pend_nxt  = clcd_pkg::init_cmd(idx_inc[1:0]);
                nib_nxt   = pend_nxt[7:4];
                phase_nxt = clcd_pkg::PH_EH_HI;
              end else begin
                idx_nxt   = 4'd0;
                phase_nxt = clcd_pkg::PH_IDLE;
                fin       = 1'b1;
              end
            end
          endcase
        end
      end
    end else if (phase_r != clcd_pkg::PH_IDLE) begin
      rej = 1'b1;
    end else if (in_kind == clcd_pkg::KIND_INIT) begin
      sel_nxt   = 1'b0;
      idx_nxt   = 4'd0;
      count_nxt = '0;
      phase_nxt = clcd_pkg::PH_POWER;
    end else begin
      sel_nxt   = (in_kind == clcd_pkg::KIND_DATA);
      idx_nxt   = clcd_pkg::IDX_SINGLE;
      pend_nxt  = in_byte_value;
      nib_nxt   = in_byte_value[7:4];
      count_nxt = '0;
      phase_nxt = clcd_pkg::PH_EH_HI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_high    <= 8'd1;
      cfg_r.pulse_recovery <= 16'd100;
      cfg_r.short_settle   <= 16'd50;
      cfg_r.long_settle    <= 16'd2000;
      cfg_r.power_on       <= 16'd20000;
      cfg_r.init_long      <= 16'd5000;
      cfg_r.init_short     <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        clcd_pkg::REG_ENABLE_HIGH:    cfg_r.enable_high    <= cfg_data[7:0];
        clcd_pkg::REG_PULSE_RECOVERY: cfg_r.pulse_recovery <= cfg_data;
        clcd_pkg::REG_SHORT_SETTLE:   cfg_r.short_settle   <= cfg_data;
        clcd_pkg::REG_LONG_SETTLE:    cfg_r.long_settle    <= cfg_data;
        clcd_pkg::REG_POWER_ON:       cfg_r.power_on       <= cfg_data;
        clcd_pkg::REG_INIT_LONG:      cfg_r.init_long      <= cfg_data;
        clcd_pkg::REG_INIT_SHORT:     cfg_r.init_short     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= clcd_pkg::PH_IDLE;
      count_r     <= '0;
      pend_r      <= 8'd0;
      sel_r       <= 1'b0;
      idx_r       <= 4'd0;
      nib_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        pend_r  <= pend_nxt;
        sel_r   <= sel_nxt;
        idx_r   <= idx_nxt;
        nib_r   <= nib_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      en_r   <= (phase_nxt == clcd_pkg::PH_EH_INIT || phase_nxt == clcd_pkg::PH_EH_HI ||
                 phase_nxt == clcd_pkg::PH_EH_LO);
      busy_r <= (phase_nxt != clcd_pkg::PH_IDLE);
      rej_r  <= rej;
      fin_r  <= fin;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_enable_line = en_r;
  assign out_select_line = sel_r;
  assign out_bus_nibble  = nib_r;
  assign out_busy_res    = busy_r;
  assign out_rejected    = rej_r;
  assign out_finished    = fin_r;

endmodule

FILE: rtl/clcd_limit.sv
module clcd_limit #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  clcd_pkg::timing_cfg_t         cfg,
  input  logic [clcd_pkg::PHASE_W-1:0]  phase,
  input  logic [3:0]                    init_index,
  input  logic                          select_level,
  input  logic [7:0]                    pending_byte,
  output logic [COUNT_WIDTH-1:0]        limit
);

  localparam logic [32:0] TOP = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic [15:0] raw;
  logic [32:0] wide;

  always_comb begin
    case (phase)
      clcd_pkg::PH_POWER: raw = cfg.power_on;
      clcd_pkg::PH_EH_INIT, clcd_pkg::PH_EH_HI, clcd_pkg::PH_EH_LO: begin
        raw = {8'd0, cfg.enable_high};
      end
      clcd_pkg::PH_REC_INIT, clcd_pkg::PH_REC_HI, clcd_pkg::PH_REC_LO: begin
        raw = cfg.pulse_recovery;
      end
      clcd_pkg::PH_INIT_WAIT: begin
        raw = (init_index == 4'd0) ? cfg.init_long : cfg.init_short;
      end
      default: begin
        if (!select_level && (pending_byte == clcd_pkg::CMD_CLEAR ||
                              pending_byte == clcd_pkg::CMD_HOME)) begin
          raw = cfg.long_settle;
        end else begin
          raw = cfg.short_settle;
        end
      end
    endcase
    wide = {17'd0, raw};
    if (wide > TOP) wide = TOP;
    if (wide == 33'd0) wide = 33'd1;
    limit = wide[COUNT_WIDTH-1:0];
  end

endmodule
